### rtl/core/cpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;
  localparam int MaxPages   = 1024;
  localparam int MaxFree    = 32;
  localparam int MaxProc    = 32;
  localparam int FIdxW      = $clog2(MaxFree);
  localparam int PIdxW      = $clog2(MaxProc);
  localparam int FCntW      = $clog2(MaxFree + 1);
  localparam int PCntW      = $clog2(MaxProc + 1);
  localparam int PageW      = 10;
  localparam int LenW       = 11;
  localparam int PidW       = 16;
  localparam int AddrW      = 20;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_COMPACT = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  // datapath commands
  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_FSCAN, C_PSCAN, C_SUM, C_CPICK, C_CPLACE, C_CFREE,
    C_PLACE, C_FOLLOW, C_FREE, C_MUL, C_RESULT
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [FIdxW-1:0] idx;
    logic [PIdxW-1:0] pidx;
    logic             append;    // free: add a new region at the table end
  } dp_cmd_t;

  typedef struct packed {
    logic             f_valid;   // free entry idx valid
    logic             p_valid;
    logic             f_fit;     // free entry fits request
    logic             p_match;
    logic             f_follow;
    logic             pick_ok;   // compaction found a process
    logic             sum_ok;
    logic             start_ok;  // count nonzero and table not full
    logic             in_range;
    logic             ftable_full;
    logic             p_cand;    // process pidx beats the current pick
    logic [1:0]       op;
  } dp_stat_t;
endpackage
`default_nettype wire

### rtl/core/cpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer: walks the tables one entry a cycle and issues datapath commands.
// ----------------------------------------------------------------------------
module cpa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic             out_busy,
  input  wire cpa_pkg::dp_stat_t st,
  output cpa_pkg::dp_cmd_t      cmd,
  output logic                  idle
);
  import cpa_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_FSCAN = 10'b0000000100,
    S_SUM   = 10'b0000001000,
    S_CPICK = 10'b0000010000,
    S_CFREE = 10'b0000100000,
    S_PSCAN = 10'b0001000000,
    S_FOLL  = 10'b0010000000,
    S_MUL   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [FIdxW-1:0] fi_r, fi_nxt;
  logic [PIdxW-1:0] pi_r, pi_nxt;
  logic [PCntW-1:0] k_r, k_nxt;
  logic             comp_r, comp_nxt;

  always_comb begin
    state_nxt = state_r; fi_nxt = fi_r; pi_nxt = pi_r; k_nxt = k_r;
    comp_nxt = comp_r;
    cmd = '{cmd: C_NONE, idx: fi_r, pidx: pi_r, append: 1'b0};
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.cmd = C_LOAD; state_nxt = S_DEC; fi_nxt = '0; pi_nxt = '0;
        comp_nxt = 1'b0;
      end
      S_DEC: begin
        if (st.op == OP_START) begin
          state_nxt = st.start_ok ? S_FSCAN : S_OUT;
        end else begin
          state_nxt = S_PSCAN;
        end
      end
      S_FSCAN: begin
        if (!st.f_valid) begin
          if (comp_r) state_nxt = S_OUT;
          else begin state_nxt = S_SUM; fi_nxt = '0; end
        end else if (st.f_fit) begin
          cmd.cmd = C_PLACE; state_nxt = S_OUT;
        end else if (fi_r == FIdxW'(MaxFree - 1)) begin
          if (comp_r) state_nxt = S_OUT;
          else begin state_nxt = S_SUM; fi_nxt = '0; end
        end else fi_nxt = fi_r + 1'b1;
      end
      S_SUM: begin
        if (st.f_valid) cmd.cmd = C_SUM;
        if (!st.f_valid || fi_r == FIdxW'(MaxFree - 1)) begin
          state_nxt = S_CPICK; pi_nxt = '0; k_nxt = '0;
        end else fi_nxt = fi_r + 1'b1;
      end
      S_CPICK: begin
        // one pass over the process table per placed process
        if (k_r == '0 && pi_r == '0 && !st.sum_ok) state_nxt = S_OUT;
        else begin
          cmd.cmd = C_CPICK;
          if (!st.p_valid || pi_r == PIdxW'(MaxProc - 1)) begin
            pi_nxt = '0;
            if (st.pick_ok || (st.p_valid && st.p_cand)) begin
              cmd.cmd = C_CPLACE; k_nxt = k_r + 1'b1;
            end else state_nxt = S_CFREE;
          end else pi_nxt = pi_r + 1'b1;
        end
      end
      S_CFREE: begin
        cmd.cmd = C_CFREE; comp_nxt = 1'b1; fi_nxt = '0; state_nxt = S_FSCAN;
      end
      S_PSCAN: begin
        if (!st.p_valid) state_nxt = S_OUT;
        else if (st.p_match) begin
          if (st.op == OP_END) begin state_nxt = S_FOLL; fi_nxt = '0; end
          else state_nxt = st.in_range ? S_MUL : S_OUT;
        end else if (pi_r == PIdxW'(MaxProc - 1)) state_nxt = S_OUT;
        else pi_nxt = pi_r + 1'b1;
      end
      S_FOLL: begin
        if (st.f_valid && st.f_follow) begin
          cmd.cmd = C_FREE; state_nxt = S_OUT;
        end else if (!st.f_valid || fi_r == FIdxW'(MaxFree - 1)) begin
          if (!st.ftable_full) begin
            cmd.cmd = C_FREE; cmd.append = 1'b1;
          end
          state_nxt = S_OUT;
        end else fi_nxt = fi_r + 1'b1;
      end
      S_MUL: begin cmd.cmd = C_MUL; state_nxt = S_OUT; end
      S_OUT: if (!out_busy) begin cmd.cmd = C_RESULT; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fi_r <= '0; pi_r <= '0; k_r <= '0; comp_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fi_r <= fi_nxt; pi_r <= pi_nxt; k_r <= k_nxt;
      comp_r <= comp_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/core/cpa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_dp
// Datapath: free and process tables, request registers, result register.
// ----------------------------------------------------------------------------
module cpa_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cpa_pkg::dp_cmd_t        cmd,
  output cpa_pkg::dp_stat_t            st,
  input  wire logic [1:0]              op_in,
  input  wire logic [cpa_pkg::PidW-1:0] pid_in,
  input  wire logic [cpa_pkg::LenW-1:0] pv_in,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_idx,
  input  wire logic [cpa_pkg::LenW-1:0] cfg_val,
  input  wire logic                    out_take,
  output logic                         out_vld,
  output logic [1:0]                   o_op,
  output logic [2:0]                   o_status,
  output logic [cpa_pkg::PageW-1:0]    o_base,
  output logic [cpa_pkg::AddrW-1:0]    o_addr
);
  import cpa_pkg::*;

  logic [PageW-1:0] fs_r [MaxFree];
  logic [LenW-1:0]  fl_r [MaxFree];
  logic [FCntW-1:0] fcnt_r;
  logic [PidW-1:0]  pid_t_r [MaxProc];
  logic [PageW-1:0] pb_r [MaxProc];
  logic [LenW-1:0]  plen_r [MaxProc];
  logic [PCntW-1:0] pcnt_r;
  logic [MaxProc-1:0] done_r;
  logic [LenW-1:0]  total_r, bytes_r;
  logic [1:0]       op_r;
  logic [PidW-1:0]  pid_r;
  logic [LenW-1:0]  pv_r;
  logic [LenW:0]    sum_r;       // never exceeds total_pages
  logic [LenW-1:0]  next_r;
  logic             pick_ok_r;
  logic [PIdxW-1:0] pick_r;
  logic [PageW-1:0] pick_base_r;
  logic [PIdxW-1:0] match_r;
  logic [2:0]       status_r;
  logic [PageW-1:0] base_r;
  logic [AddrW-1:0] addr_r;
  logic             vld_r;
  logic [LenW-1:0]  v_sat;

  logic [FIdxW-1:0] fi;
  logic [PIdxW-1:0] pi;
  logic [LenW-1:0]  end_pg;
  logic             cand;

  assign fi = cmd.idx;
  assign pi = cmd.pidx;
  assign end_pg = LenW'(pb_r[match_r]) + plen_r[match_r];
  // in compaction, a not-yet-placed process lower than the current pick
  assign cand = !done_r[pi] && (!pick_ok_r || pb_r[pi] < pick_base_r);

  always_comb begin
    st.op          = op_r;
    st.f_valid     = {1'b0, fi} < fcnt_r;
    st.p_valid     = {1'b0, pi} < pcnt_r;
    st.f_fit       = fl_r[fi] >= pv_r;
    st.p_match     = pid_t_r[pi] == pid_r;
    st.f_follow    = LenW'(fs_r[fi]) == end_pg;
    st.pick_ok     = pick_ok_r;
    st.sum_ok      = sum_r >= {1'b0, pv_r};
    st.start_ok    = pv_r != '0 && pcnt_r < PCntW'(MaxProc);
    st.in_range    = pv_r < plen_r[pi];
    st.ftable_full = fcnt_r == FCntW'(MaxFree);
    st.p_cand      = cand;
  end

  always_comb begin
    v_sat = (cfg_val == '0) ? LenW'(1) : cfg_val;
    if (v_sat > LenW'(1024)) v_sat = LenW'(1024);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= FCntW'(1); pcnt_r <= '0; total_r <= LenW'(MaxPages);
      bytes_r <= LenW'(256); fs_r[0] <= '0; fl_r[0] <= LenW'(MaxPages);
      vld_r <= 1'b0;
    end else begin
      if (out_take) vld_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_idx == CFG_TOTAL) begin
          total_r <= v_sat; fcnt_r <= FCntW'(1); pcnt_r <= '0;
          fs_r[0] <= '0; fl_r[0] <= v_sat;
        end else bytes_r <= v_sat;
      end
      unique case (cmd.cmd)
        C_LOAD: begin
          op_r <= op_in; pid_r <= pid_in; pv_r <= pv_in;
          status_r <= (op_in == OP_START) ? ST_NOSPACE : ST_UNKNOWN;
          base_r <= '0; addr_r <= '0; sum_r <= '0;
        end
        C_SUM: sum_r <= sum_r + {1'b0, fl_r[fi]};
        C_CPICK: if (st.p_valid && cand) begin
          pick_ok_r <= 1'b1; pick_r <= pi; pick_base_r <= pb_r[pi];
        end
        C_CPLACE: begin
          // last entry of the pass may itself be the pick
          if (st.p_valid && cand) begin
            pb_r[pi] <= PageW'(next_r); next_r <= next_r + plen_r[pi];
            done_r[pi] <= 1'b1;
          end else begin
            pb_r[pick_r] <= PageW'(next_r); next_r <= next_r + plen_r[pick_r];
            done_r[pick_r] <= 1'b1;
          end
          pick_ok_r <= 1'b0;
        end
        C_CFREE: begin
          if (total_r > next_r) begin
            fs_r[0] <= PageW'(next_r); fl_r[0] <= total_r - next_r;
            fcnt_r <= FCntW'(1);
          end else fcnt_r <= '0;
          status_r <= ST_COMPACT;
        end
        C_PLACE: begin
          base_r <= fs_r[fi];
          pid_t_r[pcnt_r[PIdxW-1:0]] <= pid_r;
          pb_r[pcnt_r[PIdxW-1:0]] <= fs_r[fi];
          plen_r[pcnt_r[PIdxW-1:0]] <= pv_r;
          pcnt_r <= pcnt_r + 1'b1;
          if (status_r != ST_COMPACT) status_r <= ST_DONE;
          if (fl_r[fi] == pv_r) begin
            for (int k = 0; k < MaxFree - 1; k++)
              if (k >= fi) begin fs_r[k] <= fs_r[k+1]; fl_r[k] <= fl_r[k+1]; end
            fcnt_r <= fcnt_r - 1'b1;
          end else begin
            fl_r[fi] <= fl_r[fi] - pv_r;
            fs_r[fi] <= fs_r[fi] + PageW'(pv_r);
          end
        end
        C_FREE: begin
          status_r <= ST_DONE; base_r <= pb_r[match_r];
          for (int k = 0; k < MaxProc - 1; k++)
            if (k >= match_r) begin
              pid_t_r[k] <= pid_t_r[k+1]; pb_r[k] <= pb_r[k+1];
              plen_r[k] <= plen_r[k+1];
            end
          pcnt_r <= pcnt_r - 1'b1;
          if (cmd.append) begin
            fs_r[fcnt_r[FIdxW-1:0]] <= pb_r[match_r];
            fl_r[fcnt_r[FIdxW-1:0]] <= plen_r[match_r];
            fcnt_r <= fcnt_r + 1'b1;
          end else begin
            for (int k = 0; k < MaxFree - 1; k++)
              if (k >= fi) begin fs_r[k] <= fs_r[k+1]; fl_r[k] <= fl_r[k+1]; end
            fs_r[fcnt_r[FIdxW-1:0] - 1'b1] <= pb_r[match_r];
            fl_r[fcnt_r[FIdxW-1:0] - 1'b1] <= plen_r[match_r] + fl_r[fi];
          end
        end
        C_MUL: begin
          status_r <= ST_DONE; base_r <= pb_r[match_r];
          addr_r <= AddrW'(LenW'(pb_r[match_r]) + pv_r) * AddrW'(bytes_r);
        end
        C_RESULT: vld_r <= 1'b1;
        default: ;
      endcase
      if (cmd.cmd == C_LOAD || cmd.cmd == C_CFREE) begin
        done_r <= '0; next_r <= '0; pick_ok_r <= 1'b0;
      end
      if (cmd.cmd == C_SUM) begin
        done_r <= '0; next_r <= '0; pick_ok_r <= 1'b0;
      end
      // track the scan hit for read, write and finish
      if (op_r != OP_START && st.p_valid && st.p_match && cmd.cmd == C_NONE)
        match_r <= pi;
      if (op_r != OP_START && st.p_valid && !st.in_range && st.p_match &&
          cmd.cmd == C_NONE && op_r != OP_END)
        status_r <= ST_RANGE;
      // a found finish fails only when the free table has no room
      if (op_r == OP_END && st.p_valid && st.p_match && cmd.cmd == C_NONE &&
          status_r == ST_UNKNOWN)
        status_r <= ST_NOSPACE;
    end
  end

  assign out_vld  = vld_r;
  assign o_op     = op_r;
  assign o_status = status_r;
  assign o_base   = (status_r == ST_DONE || status_r == ST_COMPACT) ? base_r : '0;
  assign o_addr   = (status_r == ST_DONE) ? addr_r : '0;
endmodule
`default_nettype wire

### rtl/core/contiguous_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit contiguous page allocator with on-the-spot compaction.
// ----------------------------------------------------------------------------
// Requests enter on in_* (operation, process_id, page_value); one result per
// request leaves on out_* (operation_echo, status, base_page, page_address).
// One request is in flight at a time: in_tready is high while the sequencer
// is idle and no result waits. A plain request scans the free and process
// tables; a start that compacts walks the process table once per process.
// The walk over the tables, one entry a cycle, sets how long a request takes.
// The result sits in an output register; while out_tready is low it holds
// and no new request is taken. Reset leaves one free region covering
// total_pages, an empty process table, total_pages 1024, page_bytes 256.
// cfg_* writes take effect at once; writing total_pages clears the tables.
// ----------------------------------------------------------------------------
module contiguous_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // operation[1:0], process_id[17:2], page_value[28:18]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // operation_echo[1:0], status[4:2], base_page[14:5],
                                       // page_address[34:15]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data
);
  import cpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     idle, in_fire;
  logic [1:0] o_op;
  logic [2:0] o_status;
  logic [PageW-1:0] o_base;
  logic [AddrW-1:0] o_addr;

  assign in_tready = idle && !out_tvalid;
  assign in_fire   = in_tvalid && in_tready;

  cpa_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_tvalid), .st, .cmd, .idle
  );

  cpa_dp u_dp (
    .clk, .rst_n, .cmd, .st,
    .op_in(in_tdata[1:0]), .pid_in(in_tdata[17:2]), .pv_in(in_tdata[28:18]),
    .cfg_we, .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .out_take(out_tvalid && out_tready), .out_vld(out_tvalid),
    .o_op, .o_status, .o_base, .o_addr
  );

  assign out_tdata = {5'd0, o_addr, o_base, o_status, o_op};

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("request accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_status <= ST_RANGE) else $error("bad status code");
endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the contiguous page allocator: requests are driven
// in bursts, answers are compared field by field with an in-bench model of
// the free-region and process tables, including compaction.
// ----------------------------------------------------------------------------
module testbench;
  import cpa_pkg::*;

  typedef struct packed {
    logic [1:0]       op;
    logic [2:0]       status;
    logic [PageW-1:0] base;
    logic [AddrW-1:0] addr;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;

  contiguous_page_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // allocator mirror
  int unsigned part_pages, bytes_per_page;
  int unsigned fr_start[MaxFree], fr_len[MaxFree];
  int          fr_cnt;
  int unsigned pr_id[MaxProc], pr_base[MaxProc], pr_len[MaxProc];
  int          pr_cnt;

  answer_t answers_due[$];
  int      errors = 0;
  bit      hold_off = 1'b0;
  int      hold_cnt = 0;
  bit      rx_busy = 1'b1;
  int      live_ids[$];

  function automatic void clear_tables();
    fr_cnt = 1;
    fr_start[0] = 0;
    fr_len[0] = part_pages;
    pr_cnt = 0;
  endfunction

  function automatic void drop_region(int i);
    for (int k = i; k + 1 < fr_cnt; k++) begin
      fr_start[k] = fr_start[k+1];
      fr_len[k] = fr_len[k+1];
    end
    fr_cnt--;
  endfunction

  function automatic void drop_proc(int i);
    for (int k = i; k + 1 < pr_cnt; k++) begin
      pr_id[k] = pr_id[k+1];
      pr_base[k] = pr_base[k+1];
      pr_len[k] = pr_len[k+1];
    end
    pr_cnt--;
  endfunction

  function automatic int find_proc(int unsigned pid);
    for (int i = 0; i < pr_cnt; i++) if (pr_id[i] == pid) return i;
    return -1;
  endfunction

  function automatic int first_fit(int unsigned n);
    for (int i = 0; i < fr_cnt; i++) if (fr_len[i] >= n) return i;
    return -1;
  endfunction

  function automatic void compact_tables();
    bit          done[MaxProc];
    int unsigned next;
    int          pick;
    next = 0;
    for (int j = 0; j < MaxProc; j++) done[j] = 1'b0;
    for (int k = 0; k < pr_cnt; k++) begin
      pick = -1;
      for (int j = 0; j < pr_cnt; j++)
        if (!done[j] && (pick < 0 || pr_base[j] < pr_base[pick])) pick = j;
      pr_base[pick] = next;
      next += pr_len[pick];
      done[pick] = 1'b1;
    end
    fr_cnt = 0;
    if (part_pages > next) begin
      fr_start[0] = next;
      fr_len[0] = part_pages - next;
      fr_cnt = 1;
    end
  endfunction

  function automatic answer_t allocate(logic [1:0] op, int unsigned pid, int unsigned pv);
    answer_t     a;
    int          i, j, follow;
    int unsigned sum, b, len;
    bit          packed_first;
    a = '0;
    a.op = op;
    a.status = ST_NOSPACE;
    if (op == OP_START) begin
      if (pv != 0 && pr_cnt < MaxProc) begin
        packed_first = 1'b0;
        i = first_fit(pv);
        if (i < 0) begin
          sum = 0;
          for (int k = 0; k < fr_cnt; k++) sum += fr_len[k];
          if (sum >= pv) begin
            compact_tables();
            packed_first = 1'b1;
            i = first_fit(pv);
          end
        end
        if (i >= 0) begin
          a.base = fr_start[i];
          pr_id[pr_cnt] = pid;
          pr_base[pr_cnt] = fr_start[i];
          pr_len[pr_cnt] = pv;
          pr_cnt++;
          fr_len[i] -= pv;
          if (fr_len[i] == 0) drop_region(i);
          else fr_start[i] += pv;
          a.status = packed_first ? ST_COMPACT : ST_DONE;
        end
      end
    end else if (op == OP_END) begin
      j = find_proc(pid);
      if (j < 0) a.status = ST_UNKNOWN;
      else begin
        b = pr_base[j];
        len = pr_len[j];
        follow = -1;
        for (int k = 0; k < fr_cnt; k++)
          if (follow < 0 && fr_start[k] == b + len) follow = k;
        if (follow >= 0) begin
          len += fr_len[follow];
          drop_region(follow);
        end
        if (follow >= 0 || fr_cnt < MaxFree) begin
          fr_start[fr_cnt] = b;
          fr_len[fr_cnt] = len;
          fr_cnt++;
          drop_proc(j);
          a.status = ST_DONE;
          a.base = b;
        end
      end
    end else begin
      j = find_proc(pid);
      if (j < 0) a.status = ST_UNKNOWN;
      else if (pv >= pr_len[j]) a.status = ST_RANGE;
      else begin
        a.status = ST_DONE;
        a.base = pr_base[j];
        a.addr = (pr_base[j] + pv) * bytes_per_page;
      end
    end
    return a;
  endfunction

  task automatic send_request(logic [1:0] op, logic [15:0] pid, logic [10:0] pv);
    answer_t a;
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, pv, pid, op};
    do @(posedge clk); while (!in_tready);
    a = allocate(op, pid, pv);
    answers_due.push_back(a);
    if (op == OP_START && (a.status == ST_DONE || a.status == ST_COMPACT))
      live_ids.push_back(pid);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (val == 0) val = 1;
    if (idx == CFG_TOTAL) begin
      part_pages = (val > MaxPages) ? MaxPages : val;
      clear_tables();
      live_ids.delete();
    end else bytes_per_page = (val > 1024) ? 1024 : val;
  endtask

  // answer checker
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[4:2], out_tdata[14:5], out_tdata[34:15]};
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer %h", $time, got);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (got.op !== want.op || got.status !== want.status || got.base !== want.base ||
            got.addr !== want.addr) begin
          $display("%0t: expected op %0d st %0d base %0d addr %0d, got op %0d st %0d base %0d addr %0d",
                   $time, want.op, want.status, want.base, want.addr,
                   got.op, got.status, got.base, got.addr);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with an optional hold-off stretch of out_tready low
  always @(posedge clk) begin
    if (!hold_off) hold_cnt = 0;
    if (hold_off && hold_cnt < 300) begin
      hold_cnt++;
      out_tready <= 1'b0;
    end else if (!rx_busy || hold_off) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 4) != 0);
  end

  task automatic test_directed();
    send_request(OP_READ, 16'h1234, 0);
    send_request(OP_END, 16'hffff, 0);
    send_request(OP_START, 16'h0001, 0);
    send_request(OP_START, 16'h0001, 100);
    send_request(OP_START, 16'hffff, 200);
    send_request(OP_START, 16'h0001, 50);
    send_request(OP_READ, 16'h0001, 99);
    send_request(OP_WRITE, 16'h0001, 100);
    send_request(OP_WRITE, 16'hffff, 199);
    send_request(OP_READ, 16'hffff, 11'h7ff);
    send_request(OP_START, 16'h0002, 11'h7ff);
    send_request(OP_END, 16'h0001, 0);
    send_request(OP_START, 16'h0003, 700);
    send_request(OP_START, 16'h0004, 74);
    send_request(OP_START, 16'h0005, 1);
    send_request(OP_END, 16'h0004, 0);
    send_request(OP_END, 16'h0003, 0);
    send_request(OP_START, 16'h0006, 1024);
    send_request(OP_START, 16'h0007, 800);
  endtask

  // mostly well-formed start/access/finish traffic on live processes
  task automatic test_random(int n, int unsigned big);
    int          k;
    logic [1:0]  op;
    logic [15:0] pid;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 3);
      pid = $urandom_range(0, 15);
      if (live_ids.size() != 0 && $urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, live_ids.size() - 1);
        pid = live_ids[k];
        if (op == OP_END && find_proc(pid) >= 0) live_ids.delete(k);
      end
      if ($urandom_range(0, 19) == 0) pid = $urandom;
      if (op == OP_START) send_request(op, pid, ($urandom_range(0, 15) == 0) ?
                                       $urandom_range(0, 2047) : $urandom_range(0, big));
      else send_request(op, pid, ($urandom_range(0, 7) == 0) ?
                        $urandom_range(0, 2047) : $urandom_range(0, 40));
    end
  endtask

  // many small processes to fill the process and free tables
  task automatic test_fragment();
    for (int i = 0; i < 40; i++) send_request(OP_START, i, $urandom_range(1, 4));
    for (int i = 0; i < 40; i += 2) send_request(OP_END, i, 0);
    send_request(OP_START, 16'h0100, 30);
    for (int i = 1; i < 40; i += 2) send_request(OP_END, i, 0);
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    settle();
    hold_off = 1'b1;
    test_random(20, 30);
    settle();
    hold_off = 1'b0;
  endtask

  initial begin
    part_pages = 1024;
    bytes_per_page = 256;
    clear_tables();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    rx_busy = 1'b0;
    test_random(120, 100);
    rx_busy = 1'b1;
    test_fragment();
    test_backpressure();
    write_reg(CFG_BYTES, 11'd1024);
    test_random(100, 200);
    write_reg(CFG_BYTES, 11'd0);
    write_reg(CFG_TOTAL, 11'd1);
    test_random(60, 2);
    write_reg(CFG_TOTAL, 11'h7ff);
    write_reg(CFG_BYTES, 11'h7ff);
    test_random(120, 300);
    write_reg(CFG_TOTAL, 11'd64);
    write_reg(CFG_BYTES, 11'd3);
    test_fragment();
    test_random(200, 12);
    write_reg(CFG_TOTAL, 11'd1024);
    write_reg(CFG_BYTES, 11'd1);
    test_random(100, 90);
    settle();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

### files.f
rtl/core/cpa_pkg.sv
rtl/core/cpa_ctrl.sv
rtl/core/cpa_dp.sv
rtl/core/contiguous_page_allocator.sv
dv/testbench.sv
